### rtl/psg_pkg.sv
// Shared types, codes and constant functions of the sound generator.
package psg_pkg;

	localparam int GAIN_W   = 15;
	localparam int REG_W    = 10;
	localparam int STEP_W   = 16;
	localparam int TAP_W    = 17;
	localparam int PERIOD_W = 28;
	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 13;
	localparam int CFG_IDX_W = 3;

	localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_BATCH  = 2'd1;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WHITE_TAPS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TAPS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED  = 3'd3;

	localparam logic [2:0] REG_TONE0  = 3'd0;
	localparam logic [2:0] REG_TONE1  = 3'd2;
	localparam logic [2:0] REG_TONE2  = 3'd4;
	localparam logic [2:0] REG_NOISE  = 3'd6;
	localparam logic [1:0] NOISE_RATE_TONE2 = 2'd3;

	localparam logic [STEP_W-1:0] RST_UPDATE_STEP = 16'd32768;
	localparam logic [TAP_W-1:0]  RST_WHITE_TAPS  = 17'd73728;
	localparam logic [TAP_W-1:0]  RST_PERIOD_TAPS = 17'd32768;
	localparam logic [TAP_W-1:0]  RST_NOISE_SEED  = 17'd3893;

	localparam logic [63:0] ATTEN_K = 64'd3411613790;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_BATCH,
		KIND_SAMPLE
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] cmd_byte;
		logic [LEN_W-1:0]  len;
	} cmd_t;

	typedef struct packed {
		logic [STEP_W-1:0] update_step;
		logic [TAP_W-1:0]  white_taps;
		logic [TAP_W-1:0]  periodic_taps;
		logic [TAP_W-1:0]  seed;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TONE_START,
		ST_TONE_LOOP,
		ST_TONE_END,
		ST_NOISE_START,
		ST_NOISE_LOOP,
		ST_MUL,
		ST_ACC,
		ST_MIX
	} state_t;

	// 2 dB attenuation ladder, evaluated with constant arguments only
	function automatic logic [GAIN_W-1:0] atten_entry(input int full_scale, input int idx);
		logic [63:0] v;
		v = 64'(full_scale / 3) << 16;
		for (int i = 0; i < 15; i++) begin
			if (i < idx)
				v = (v * ATTEN_K) >> 32;
		end
		if (idx >= 15)
			return '0;
		return GAIN_W'(v >> 16);
	endfunction

endpackage

### rtl/psg_tone_noise_generator_unit.sv
// Top level of the four-voice tone and noise sound generator.
// Usage:
//  - Input channel (in_valid/in_ready) carries operation, command_byte and
//    batch_length. Operation 0 writes a command byte, 1 begins a render
//    batch, 2 renders one sample; operation 3 is accepted and dropped.
//  - A four-entry request queue sits between the front end and the
//    execution engine, so requests are taken while a sample is rendered.
//  - Output channel (out_valid/out_ready) returns one signed 16-bit sample
//    for each render request, in order, held in an output register.
//  - Config channel (cfg_valid/cfg_ready, always ready) writes update step,
//    white and periodic noise taps and the noise seed; unknown indexes drop.
// Flow: an accepted request is registered in the queue before the engine
//  sees it. Writes and batch starts are executed in the engine's idle state.
//  A sample steps each tone voice through start, loop, end, multiply and
//  accumulate states, the noise voice through start, loop, multiply and
//  accumulate states, then a mix step. One sample is rendered at a time.
// Reset: all voices silent, periods and counters at the reset update step,
//  noise shifter at the reset seed. A stalled receiver holds the sample and
//  the engine stops at its mix step until the output register frees.
module psg_tone_noise_generator_unit #(
	parameter int FRAC_BITS  = 16,
	parameter int FULL_SCALE = 32767
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [psg_pkg::OP_W-1:0]        operation,
	input  logic [psg_pkg::BYTE_W-1:0]      command_byte,
	input  logic [psg_pkg::LEN_W-1:0]       batch_length,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [15:0]              sample,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [psg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psg_pkg::TAP_W-1:0]       cfg_data
);

	psg_pkg::cfg_t cfg_q;
	psg_pkg::cmd_t cmd;
	logic          cmd_valid, cmd_ready;

	// config registers are always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.update_step   <= psg_pkg::RST_UPDATE_STEP;
			cfg_q.white_taps    <= psg_pkg::RST_WHITE_TAPS;
			cfg_q.periodic_taps <= psg_pkg::RST_PERIOD_TAPS;
			cfg_q.seed          <= psg_pkg::RST_NOISE_SEED;
		end else if (cfg_valid) begin
			case (cfg_index)
				psg_pkg::CFG_UPDATE_STEP: cfg_q.update_step   <= cfg_data[15:0];
				psg_pkg::CFG_WHITE_TAPS:  cfg_q.white_taps    <= cfg_data;
				psg_pkg::CFG_PERIOD_TAPS: cfg_q.periodic_taps <= cfg_data;
				psg_pkg::CFG_NOISE_SEED:  cfg_q.seed          <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end: accept, classify, queue
	psg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.command_byte (command_byte),
		.batch_length (batch_length),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd)
	);

	// back end: register file, voice stepping, mix
	psg_back #(
		.FRAC_BITS  (FRAC_BITS),
		.FULL_SCALE (FULL_SCALE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample)
	);

endmodule

### rtl/psg_front.sv
// Front end: accepts items, classifies the operation and queues commands.
module psg_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [psg_pkg::OP_W-1:0]    operation,
	input  logic [psg_pkg::BYTE_W-1:0]  command_byte,
	input  logic [psg_pkg::LEN_W-1:0]   batch_length,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output psg_pkg::cmd_t               cmd
);

	localparam int DEPTH = 4;
	localparam int PTR_W = 2;

	psg_pkg::cmd_t    fifo_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push, pop, known;
	psg_pkg::cmd_t    entry;

	always_comb begin
		known = 1'b1;
		entry.cmd_byte = command_byte;
		entry.len      = batch_length;
		entry.kind     = psg_pkg::KIND_WRITE;
		unique case (operation)
			psg_pkg::OP_WRITE:  entry.kind = psg_pkg::KIND_WRITE;
			psg_pkg::OP_BATCH:  entry.kind = psg_pkg::KIND_BATCH;
			psg_pkg::OP_SAMPLE: entry.kind = psg_pkg::KIND_SAMPLE;
			default:            known = 1'b0;
		endcase
	end

	assign in_ready  = (count_q != (PTR_W+1)'(DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	// drop unknown operations at the door
	assign push      = in_valid && in_ready && known;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(DEPTH)) else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == (PTR_W+1)'(DEPTH)) |-> !push) else $error("push into full queue");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("pointers disagree");

endmodule

### rtl/psg_back.sv
// Back end: executes register writes, batch starts and sample rendering.
module psg_back #(
	parameter int FRAC_BITS  = 16,
	parameter int FULL_SCALE = 32767
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  psg_pkg::cmd_t        cmd,
	input  psg_pkg::cfg_t        cfg,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   sample
);

	localparam int CW  = (FRAC_BITS + 15 > 30) ? FRAC_BITS + 15 : 30;
	localparam int AW  = CW + 2;
	localparam int FW  = FRAC_BITS + 2;
	localparam int PRW = FW + 16;
	localparam int SW  = FRAC_BITS + 20;
	localparam int PW  = psg_pkg::PERIOD_W;
	localparam int GW  = psg_pkg::GAIN_W;
	localparam int RW  = psg_pkg::REG_W;
	localparam int TW  = psg_pkg::TAP_W;
	localparam logic signed [CW-1:0] STEP_UNITS = CW'(1) << FRAC_BITS;
	localparam logic signed [SW-FRAC_BITS-1:0] SAT_HI = (SW-FRAC_BITS)'(32767);
	localparam logic signed [SW-FRAC_BITS-1:0] SAT_LO = -(SW-FRAC_BITS)'(32768);

	psg_pkg::state_t state_q, state_d;

	logic [GW-1:0]          gain_tbl [16];
	logic [RW-1:0]          tone_reg_q [3];
	logic [1:0]             noise_reg_q;
	logic [2:0]             latch_q;
	logic [PW-1:0]          period_q [4];
	logic signed [CW-1:0]   counter_q [4];
	logic [3:0]             level_q;
	logic [GW-1:0]          gain_q [4];
	logic [TW-1:0]          shifter_q, feedback_q;
	logic [1:0]             voice_q;
	logic signed [AW-1:0]   area_q;
	logic signed [CW-1:0]   left_q;
	logic signed [PRW-1:0]  prod_q;
	logic signed [SW-1:0]   sum_q;
	logic                   out_valid_q;
	logic signed [15:0]     sample_q;

	always_comb begin
		for (int i = 0; i < 16; i++)
			gain_tbl[i] = psg_pkg::atten_entry(FULL_SCALE, i);
	end

	logic take;
	assign take = cmd_valid && cmd_ready;

	// register write decode
	logic          b7;
	logic [2:0]    wr_r;
	logic          wr_tone;
	logic [1:0]    wr_t;
	logic [RW-1:0] wr_val;
	logic [25:0]   wr_prod;
	logic [PW-1:0] wr_period;
	always_comb begin
		b7      = cmd.cmd_byte[7];
		wr_r    = b7 ? cmd.cmd_byte[6:4] : latch_q;
		wr_t    = wr_r[2:1];
		wr_tone = !wr_r[0] && (wr_r != psg_pkg::REG_NOISE);
		wr_val  = '0;
		if (wr_tone) begin
			if (b7)
				wr_val = {tone_reg_q[wr_t][RW-1:4], cmd.cmd_byte[3:0]};
			else
				wr_val = {cmd.cmd_byte[5:0], tone_reg_q[wr_t][3:0]};
		end
		wr_prod   = cfg.update_step * wr_val;
		wr_period = (wr_prod == '0) ? PW'(cfg.update_step) : PW'(wr_prod);
	end

	// tone iteration on the selected voice
	logic signed [CW-1:0] cur_cnt, cur_per, t_c1, t_c2;
	logic                 cur_lvl;
	always_comb begin
		cur_cnt = counter_q[voice_q];
		cur_per = $signed({{(CW-PW){1'b0}}, period_q[voice_q]});
		cur_lvl = level_q[voice_q];
		t_c1    = cur_cnt + cur_per;
		t_c2    = t_c1 + cur_per;
	end

	// noise iteration
	logic signed [CW-1:0] n_cnt, n_per, n_ev, n_c2, n_c3;
	logic signed [AW-1:0] n_a1, n_a2, n_a3;
	logic [TW-1:0]        n_sh, n_mix;
	logic                 n_lvl;
	always_comb begin
		n_cnt = counter_q[3];
		n_per = $signed({{(CW-PW){1'b0}}, period_q[3]});
		n_ev  = (n_cnt < left_q) ? n_cnt : left_q;
		n_a1  = area_q + (level_q[3] ? AW'(n_cnt) : '0);
		n_c2  = n_cnt - n_ev;
		n_mix = shifter_q[0] ? (shifter_q ^ feedback_q) : shifter_q;
		n_sh  = shifter_q;
		n_lvl = level_q[3];
		n_c3  = n_c2;
		n_a2  = n_a1;
		if (n_c2 <= 0) begin
			n_sh  = n_mix >> 1;
			n_lvl = n_sh[0];
			n_c3  = n_c2 + n_per;
			n_a2  = n_a1 + (n_lvl ? AW'(n_per) : '0);
		end
		n_a3 = n_a2 - (n_lvl ? AW'(n_c3) : '0);
	end

	// mix and saturate; the shift rounds toward minus infinity
	logic signed [SW-1:0]            shifted;
	logic signed [SW-FRAC_BITS-1:0]  mixed;
	always_comb begin
		shifted = sum_q >>> FRAC_BITS;
		mixed   = shifted[SW-FRAC_BITS-1:0];
	end

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psg_pkg::ST_IDLE:
				if (cmd_valid && cmd.kind == psg_pkg::KIND_SAMPLE)
					state_d = psg_pkg::ST_TONE_START;
			psg_pkg::ST_TONE_START: state_d = psg_pkg::ST_TONE_LOOP;
			psg_pkg::ST_TONE_LOOP:
				if (cur_cnt > 0 || t_c1 > 0)
					state_d = psg_pkg::ST_TONE_END;
			psg_pkg::ST_TONE_END:   state_d = psg_pkg::ST_MUL;
			psg_pkg::ST_NOISE_START: state_d = psg_pkg::ST_NOISE_LOOP;
			psg_pkg::ST_NOISE_LOOP:
				if (left_q - n_ev <= 0)
					state_d = psg_pkg::ST_MUL;
			psg_pkg::ST_MUL:        state_d = psg_pkg::ST_ACC;
			psg_pkg::ST_ACC:
				if (voice_q == 2'd3)
					state_d = psg_pkg::ST_MIX;
				else if (voice_q == 2'd2)
					state_d = psg_pkg::ST_NOISE_START;
				else
					state_d = psg_pkg::ST_TONE_START;
			psg_pkg::ST_MIX:
				if (out_free)
					state_d = psg_pkg::ST_IDLE;
			default: state_d = psg_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_ready = (state_q == psg_pkg::ST_IDLE);
		out_valid = out_valid_q;
		sample    = sample_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= psg_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// raise on the mix step, drop when the sample is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == psg_pkg::ST_MIX && out_free)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				tone_reg_q[i] <= '0;
			for (int i = 0; i < 4; i++) begin
				period_q[i]  <= PW'(psg_pkg::RST_UPDATE_STEP);
				counter_q[i] <= CW'(psg_pkg::RST_UPDATE_STEP);
				gain_q[i]    <= '0;
			end
			noise_reg_q <= '0;
			latch_q     <= '0;
			level_q     <= {psg_pkg::RST_NOISE_SEED[0], 3'b000};
			shifter_q   <= psg_pkg::RST_NOISE_SEED;
			feedback_q  <= '0;
			voice_q     <= '0;
			area_q      <= '0;
			left_q      <= '0;
			prod_q      <= '0;
			sum_q       <= '0;
			sample_q    <= '0;
		end else begin
			unique case (state_q)
				psg_pkg::ST_IDLE: begin
					voice_q <= '0;
					if (take && cmd.kind == psg_pkg::KIND_WRITE) begin
						if (b7)
							latch_q <= wr_r;
						if (wr_tone) begin
							tone_reg_q[wr_t] <= wr_val;
							period_q[wr_t]   <= wr_period;
							if (wr_r == psg_pkg::REG_TONE2 &&
							    noise_reg_q == psg_pkg::NOISE_RATE_TONE2)
								period_q[3] <= wr_period << 1;
						end else if (b7 && wr_r == psg_pkg::REG_NOISE) begin
							noise_reg_q <= cmd.cmd_byte[1:0];
							feedback_q  <= cmd.cmd_byte[2] ? cfg.white_taps
							                               : cfg.periodic_taps;
							if (cmd.cmd_byte[1:0] == psg_pkg::NOISE_RATE_TONE2)
								period_q[3] <= period_q[2] << 1;
							else
								period_q[3] <= PW'(cfg.update_step) << (5 + cmd.cmd_byte[1:0]);
							shifter_q  <= cfg.seed;
							level_q[3] <= cfg.seed[0];
						end else if (b7 && wr_r[0]) begin
							gain_q[wr_r[2:1]] <= gain_tbl[cmd.cmd_byte[3:0]];
						end
					end else if (take && cmd.kind == psg_pkg::KIND_BATCH) begin
						for (int i = 0; i < 4; i++) begin
							if (gain_q[i] == '0 &&
							    counter_q[i] <= (CW'(cmd.len) << FRAC_BITS))
								counter_q[i] <= counter_q[i] + (CW'(cmd.len) << FRAC_BITS);
						end
					end
				end
				psg_pkg::ST_TONE_START: begin
					area_q <= cur_lvl ? AW'(cur_cnt) : '0;
					counter_q[voice_q] <= cur_cnt - STEP_UNITS;
				end
				psg_pkg::ST_TONE_LOOP: begin
					if (cur_cnt <= 0) begin
						if (t_c1 > 0) begin
							counter_q[voice_q] <= t_c1;
							level_q[voice_q]   <= !cur_lvl;
							if (!cur_lvl)
								area_q <= area_q + AW'(cur_per);
						end else begin
							counter_q[voice_q] <= t_c2;
							area_q <= area_q + AW'(cur_per);
						end
					end
				end
				psg_pkg::ST_TONE_END:
					area_q <= area_q - (cur_lvl ? AW'(cur_cnt) : '0);
				psg_pkg::ST_NOISE_START: begin
					area_q <= '0;
					left_q <= STEP_UNITS;
				end
				psg_pkg::ST_NOISE_LOOP: begin
					area_q       <= n_a3;
					counter_q[3] <= n_c3;
					shifter_q    <= n_sh;
					level_q[3]   <= n_lvl;
					left_q       <= left_q - n_ev;
				end
				psg_pkg::ST_MUL:
					prod_q <= $signed(area_q[FW-1:0]) * $signed({1'b0, gain_q[voice_q]});
				psg_pkg::ST_ACC: begin
					sum_q   <= ((voice_q == 2'd0) ? '0 : sum_q) + SW'(prod_q);
					voice_q <= voice_q + 1'b1;
				end
				psg_pkg::ST_MIX:
					if (out_free) begin
						if (mixed > SAT_HI)
							sample_q <= 16'sh7FFF;
						else if (mixed < SAT_LO)
							sample_q <= 16'sh8000;
						else
							sample_q <= mixed[15:0];
					end
				default: ;
			endcase
		end
	end

	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psg_pkg::ST_IDLE) |-> (counter_q[0] > 0 && counter_q[1] > 0 &&
		counter_q[2] > 0 && counter_q[3] > 0)) else $error("voice counter not positive");
	a_noise_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psg_pkg::ST_NOISE_LOOP) |-> (left_q > 0)) else $error("noise step overrun");
	a_out_from_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == psg_pkg::ST_MIX)) else $error("stray sample");

endmodule

### tb/sv/tb_psg_tone_noise_generator_unit.sv
// Self-checking testbench for the four-voice tone and noise sound generator.
module tb_psg_tone_noise_generator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 64;
	localparam longint SAMPLE_UNITS = 64'sd65536;
	localparam logic [psg_pkg::OP_W-1:0] OP_DROPPED = 2'd3;
	localparam logic [psg_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

	// Holds its own copy of the chip state and predicts every rendered sample.
	class sample_scoreboard;
		int unsigned step_units;
		bit [psg_pkg::TAP_W-1:0] white_taps;
		bit [psg_pkg::TAP_W-1:0] periodic_taps;
		bit [psg_pkg::TAP_W-1:0] seed;
		bit [psg_pkg::REG_W-1:0] chip_reg [8];
		bit [2:0] latched;
		longint period [4];
		longint counter [4];
		bit level [4];
		longint gain [4];
		bit [psg_pkg::TAP_W-1:0] shifter;
		bit [psg_pkg::TAP_W-1:0] feedback;
		longint atten [16];
		shortint expected_samples [$];
		int mismatches;
		int checked;

		function new();
			longint unsigned v;
			step_units = psg_pkg::RST_UPDATE_STEP;
			white_taps = psg_pkg::RST_WHITE_TAPS;
			periodic_taps = psg_pkg::RST_PERIOD_TAPS;
			seed = psg_pkg::RST_NOISE_SEED;
			latched = 0;
			for (int i = 0; i < 8; i++)
				chip_reg[i] = i[0] ? 10'h00f : 10'h000;
			for (int i = 0; i < 4; i++) begin
				gain[i] = 0;
				level[i] = 0;
				period[i] = step_units;
				counter[i] = step_units;
			end
			shifter = seed;
			level[3] = shifter[0];
			feedback = 0;
			v = longint'(32767 / 3) << 16;
			for (int i = 0; i < 15; i++) begin
				atten[i] = longint'(v >> 16);
				v = (v * 64'd3411613790) >> 32;
			end
			atten[15] = 0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_cfg(bit [psg_pkg::CFG_IDX_W-1:0] idx,
			bit [psg_pkg::TAP_W-1:0] data);
			case (idx)
				psg_pkg::CFG_UPDATE_STEP: step_units = data[psg_pkg::STEP_W-1:0];
				psg_pkg::CFG_WHITE_TAPS:  white_taps = data;
				psg_pkg::CFG_PERIOD_TAPS: periodic_taps = data;
				psg_pkg::CFG_NOISE_SEED:  seed = data;
				default: ;
			endcase
		endfunction

		function void load_tone_period(bit [2:0] r);
			int c;
			c = r >> 1;
			period[c] = longint'(step_units) * longint'(chip_reg[r]);
			if (period[c] == 0)
				period[c] = step_units;
			if (r == psg_pkg::REG_TONE2 &&
			    chip_reg[psg_pkg::REG_NOISE][1:0] == psg_pkg::NOISE_RATE_TONE2)
				period[3] = 2 * period[2];
		endfunction

		function longint step_tone(int c);
			longint area;
			area = level[c] ? counter[c] : 0;
			counter[c] -= SAMPLE_UNITS;
			while (counter[c] <= 0) begin
				counter[c] += period[c];
				if (counter[c] > 0) begin
					level[c] ^= 1'b1;
					if (level[c])
						area += period[c];
					break;
				end
				counter[c] += period[c];
				area += period[c];
			end
			if (level[c])
				area -= counter[c];
			return area;
		endfunction

		function longint step_noise();
			longint left;
			longint area;
			longint ev;
			left = SAMPLE_UNITS;
			area = 0;
			do begin
				ev = counter[3] < left ? counter[3] : left;
				if (level[3])
					area += counter[3];
				counter[3] -= ev;
				if (counter[3] <= 0) begin
					if (shifter[0])
						shifter ^= feedback;
					shifter = shifter >> 1;
					level[3] = shifter[0];
					counter[3] += period[3];
					if (level[3])
						area += period[3];
				end
				if (level[3])
					area -= counter[3];
				left -= ev;
			end while (left > 0);
			return area;
		endfunction

		// Note one accepted request and queue the sample it produces, if any.
		function void note_request(bit [psg_pkg::OP_W-1:0] op, bit [psg_pkg::BYTE_W-1:0] b,
			bit [psg_pkg::LEN_W-1:0] len);
			bit [2:0] r;
			longint bump;
			longint sum;
			if (op == psg_pkg::OP_WRITE) begin
				if (b[7]) begin
					r = b[6:4];
					latched = r;
					chip_reg[r] = (chip_reg[r] & 10'h3f0) | psg_pkg::REG_W'(b[3:0]);
					if (r == psg_pkg::REG_TONE0 || r == psg_pkg::REG_TONE1 ||
					    r == psg_pkg::REG_TONE2) begin
						load_tone_period(r);
					end else if (r == psg_pkg::REG_NOISE) begin
						feedback = chip_reg[r][2] ? white_taps : periodic_taps;
						if (chip_reg[r][1:0] == psg_pkg::NOISE_RATE_TONE2)
							period[3] = 2 * period[2];
						else
							period[3] = longint'(step_units) << (5 + chip_reg[r][1:0]);
						shifter = seed;
						level[3] = shifter[0];
					end else begin
						gain[r >> 1] = atten[b[3:0]];
					end
				end else begin
					r = latched;
					if (r == psg_pkg::REG_TONE0 || r == psg_pkg::REG_TONE1 ||
					    r == psg_pkg::REG_TONE2) begin
						chip_reg[r] = (chip_reg[r] & 10'h00f) | (psg_pkg::REG_W'(b[5:0]) << 4);
						load_tone_period(r);
					end
				end
			end else if (op == psg_pkg::OP_BATCH) begin
				bump = longint'(len) << 16;
				for (int i = 0; i < 4; i++)
					if (gain[i] == 0 && counter[i] <= bump)
						counter[i] += bump;
			end else if (op == psg_pkg::OP_SAMPLE) begin
				sum = 0;
				for (int i = 0; i < 3; i++)
					sum += step_tone(i) * gain[i];
				sum += step_noise() * gain[3];
				if (sum >= 0)
					sum = sum >>> 16;
				else
					sum = -(((-sum) + SAMPLE_UNITS - 1) >>> 16);
				if (sum > 32767)
					sum = 32767;
				if (sum < -32768)
					sum = -32768;
				expected_samples.push_back(shortint'(sum));
			end
		endfunction

		task report(string what);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		task check_sample(logic signed [15:0] got);
			shortint want;
			checked++;
			if (expected_samples.size() == 0) begin
				report($sformatf("sample %0d arrived with nothing outstanding", got));
			end else begin
				want = expected_samples.pop_front();
				if (got !== want)
					report($sformatf("sample got %0d want %0d", got, want));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [psg_pkg::OP_W-1:0] operation;
	logic [psg_pkg::BYTE_W-1:0] command_byte;
	logic [psg_pkg::LEN_W-1:0] batch_length;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] sample;
	logic cfg_valid;
	logic cfg_ready;
	logic [psg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [psg_pkg::TAP_W-1:0] cfg_data;

	sample_scoreboard sb;
	bit no_idle;        // phases with back-to-back traffic on both sides
	int requests_sent;
	int idle_cycles = 0;

	psg_tone_noise_generator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .command_byte(command_byte), .batch_length(batch_length),
		.out_valid(out_valid), .out_ready(out_ready), .sample(sample),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hold one request until the block takes it; leave valid high when the
	// next request follows without a gap, so valid never drops and rises in one step.
	task send_request(logic [psg_pkg::OP_W-1:0] op, logic [psg_pkg::BYTE_W-1:0] b,
		logic [psg_pkg::LEN_W-1:0] len);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		command_byte <= b;
		batch_length <= len;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		sb.note_request(op, b, len);
		requests_sent++;
	endtask

	task write_reg(logic [psg_pkg::CFG_IDX_W-1:0] idx, logic [psg_pkg::TAP_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		cfg_valid <= 1'b0;
		sb.write_cfg(idx, data);
	endtask

	// Drop valid and let every outstanding sample drain, then let queued
	// writes and batch starts retire before touching the registers.
	task wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_all_regs(int unsigned stp, int unsigned wt, int unsigned pt, int unsigned sd);
		write_reg(psg_pkg::CFG_UPDATE_STEP, psg_pkg::TAP_W'(stp));
		write_reg(psg_pkg::CFG_WHITE_TAPS, psg_pkg::TAP_W'(wt));
		write_reg(psg_pkg::CFG_PERIOD_TAPS, psg_pkg::TAP_W'(pt));
		write_reg(psg_pkg::CFG_NOISE_SEED, psg_pkg::TAP_W'(sd));
	endtask

	// Mostly latch/data pairs and samples with random content, some batch
	// starts and a few dropped operation-3 requests.
	task send_random(int count);
		int pick;
		logic [2:0] r;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				r = $urandom_range(0, 7);
				send_request(psg_pkg::OP_WRITE, {1'b1, r, 4'($urandom_range(0, 15))},
					psg_pkg::LEN_W'($urandom));
				if ($urandom_range(0, 1))
					send_request(psg_pkg::OP_WRITE, {1'b0, 7'($urandom)},
						psg_pkg::LEN_W'($urandom));
			end else if (pick < 35) begin
				send_request(psg_pkg::OP_WRITE, psg_pkg::BYTE_W'($urandom),
					psg_pkg::LEN_W'($urandom));
			end else if (pick < 85) begin
				send_request(psg_pkg::OP_SAMPLE, psg_pkg::BYTE_W'($urandom),
					psg_pkg::LEN_W'($urandom));
			end else if (pick < 96) begin
				send_request(psg_pkg::OP_BATCH, psg_pkg::BYTE_W'($urandom),
					$urandom_range(0, 9) == 0 ? psg_pkg::LEN_W'(4096)
					                          : psg_pkg::LEN_W'($urandom_range(0, 4095)));
			end else begin
				send_request(OP_DROPPED, psg_pkg::BYTE_W'($urandom), psg_pkg::LEN_W'($urandom));
			end
		end
	endtask

	task send_directed();
		send_request(psg_pkg::OP_SAMPLE, 8'h00, 13'd0);            // all voices silent
		send_request(psg_pkg::OP_WRITE, 8'h8f, 13'd0);             // tone 0 low bits
		send_request(psg_pkg::OP_WRITE, 8'h3f, 13'd0);             // tone 0 high bits, max period
		send_request(psg_pkg::OP_WRITE, 8'h90, 13'd0);             // tone 0 loudest
		send_request(psg_pkg::OP_SAMPLE, 8'hff, 13'h1fff);
		send_request(psg_pkg::OP_WRITE, 8'ha0, 13'd0);             // tone 1 period zero
		send_request(psg_pkg::OP_WRITE, 8'h00, 13'd0);
		send_request(psg_pkg::OP_WRITE, 8'hb5, 13'd0);
		send_request(psg_pkg::OP_SAMPLE, 8'h00, 13'd0);
		send_request(psg_pkg::OP_WRITE, 8'hc3, 13'd0);             // tone 2
		send_request(psg_pkg::OP_WRITE, 8'he7, 13'd0);             // white noise at tone 2 rate
		send_request(psg_pkg::OP_WRITE, 8'h45, 13'd0);             // data byte to noise: ignored
		send_request(psg_pkg::OP_WRITE, 8'hc1, 13'd0);             // tone 2 change follows noise
		send_request(psg_pkg::OP_WRITE, 8'hf0, 13'd0);             // noise loudest
		send_request(psg_pkg::OP_SAMPLE, 8'h00, 13'd0);
		send_request(psg_pkg::OP_WRITE, 8'he0, 13'd0);             // periodic, fastest rate
		send_request(psg_pkg::OP_WRITE, 8'hd0, 13'd0);             // tone 2 loudest
		send_request(psg_pkg::OP_WRITE, 8'h7f, 13'd0);             // data byte to volume: ignored
		send_request(psg_pkg::OP_SAMPLE, 8'h00, 13'd0);
		send_request(psg_pkg::OP_BATCH, 8'h00, 13'd0);
		send_request(psg_pkg::OP_BATCH, 8'h00, 13'd4096);
		send_request(OP_DROPPED, 8'hff, 13'h1fff);                 // dropped
		send_request(psg_pkg::OP_WRITE, 8'he6, 13'd0);             // white, slowest fixed rate
		send_request(psg_pkg::OP_SAMPLE, 8'h00, 13'd0);
		send_request(psg_pkg::OP_SAMPLE, 8'h00, 13'd0);
	endtask

	// Smallest update step: keep tone and noise periods long so the stepping
	// loops of a sample stay short.
	task run_slow_step_phase();
		logic [2:0] r;
		send_request(psg_pkg::OP_WRITE, 8'h8f, 13'd0);
		send_request(psg_pkg::OP_WRITE, 8'h3f, 13'd0);
		send_request(psg_pkg::OP_WRITE, 8'haf, 13'd0);
		send_request(psg_pkg::OP_WRITE, 8'h3f, 13'd0);
		send_request(psg_pkg::OP_WRITE, 8'hcf, 13'd0);
		send_request(psg_pkg::OP_WRITE, 8'h3f, 13'd0);
		send_request(psg_pkg::OP_WRITE, 8'he7, 13'd0);
		for (int i = 0; i < 24; i++) begin
			case ($urandom_range(0, 3))
				0: begin
					r = {2'($urandom_range(0, 3)), 1'b1};
					send_request(psg_pkg::OP_WRITE, {1'b1, r, 4'($urandom_range(0, 15))}, 13'd0);
				end
				1: send_request(psg_pkg::OP_BATCH, 8'h00,
					psg_pkg::LEN_W'($urandom_range(0, 4096)));
				default: send_request(psg_pkg::OP_SAMPLE, 8'h00, 13'd0);
			endcase
		end
	endtask

	// Receiver: stall a random number of cycles before each sample.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			forever begin
				@(posedge clk);
				if (out_valid)
					break;
			end
		end
	end

	// Check each sample on the edge that moves it.
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_sample(sample);

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		sb = new();
		no_idle = 1'b0;
		requests_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = '0;
		command_byte = '0;
		batch_length = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		send_random(240);
		for (int ph = 1; ph < 9; ph++) begin
			wait_idle();
			no_idle = (ph % 3 == 2);
			case (ph)
				1: write_all_regs(65535, 131071, 0, 131071);
				2: write_all_regs(1, 0, 131071, 0);
				3: begin
					write_all_regs(256, $urandom_range(0, 131071), $urandom_range(0, 131071), 1);
					write_reg(CFG_UNUSED, psg_pkg::TAP_W'($urandom));   // unknown index: dropped
				end
				8: write_all_regs(psg_pkg::RST_UPDATE_STEP, psg_pkg::RST_WHITE_TAPS,
					psg_pkg::RST_PERIOD_TAPS, psg_pkg::RST_NOISE_SEED);
				default: write_all_regs($urandom_range(256, 65535), $urandom_range(0, 131071),
					$urandom_range(0, 131071), $urandom_range(0, 131071));
			endcase
			if (ph == 2)
				run_slow_step_phase();
			else
				send_random(220);
		end

		in_valid <= 1'b0;
		while (sb.expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests over nine register settings, checked %0d samples.",
			requests_sent, sb.checked);
		$display("Mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/psg_pkg.sv
rtl/psg_front.sv
rtl/psg_back.sv
rtl/psg_tone_noise_generator_unit.sv
tb/sv/tb_psg_tone_noise_generator_unit.sv
